>>> rtl/core/rbs_pkg.sv
// Shared types and constants for the RGB565 bilinear sampler.
`timescale 1ns / 1ps

package rbs_pkg;

  localparam int RED_W  = 5;
  localparam int GRN_W  = 6;
  localparam int BLU_W  = 5;
  localparam int PIX_W  = 16;
  localparam int FRAC_W = 8;

  // Bit positions of each channel inside an RGB565 word
  localparam int RED_LSB = 11;
  localparam int GRN_LSB = 5;
  localparam int BLU_LSB = 0;

  // Unit weight (1.0 in 1/256 steps) and rounding bias for the final >> 16
  localparam logic [FRAC_W:0] WEIGHT_ONE = 9'd256;
  localparam logic [15:0]     ROUND_BIAS = 16'h8000;
  localparam int              OUT_SHIFT  = 16;

  // Sideband carried alongside the horizontal blend stage
  typedef struct packed {
    logic              vld;
    logic              uni;
    logic              we;
    logic [PIX_W-1:0]  pix;
    logic [FRAC_W-1:0] fy;
  } rbs_s1_t;

  // Sideband carried alongside the vertical blend stage
  typedef struct packed {
    logic             vld;
    logic             uni;
    logic             we;
    logic [PIX_W-1:0] pix;
  } rbs_s2_t;

endpackage

>>> rtl/core/rbs_hblend.sv
// Horizontal blend of one color channel for the top and bottom pixel rows.
`timescale 1ns / 1ps

module rbs_hblend
  import rbs_pkg::*;
#(
  parameter int CW = 5
) (
  input  logic                clk,
  input  logic [CW-1:0]       tl,
  input  logic [CW-1:0]       tr,
  input  logic [CW-1:0]       bl,
  input  logic [CW-1:0]       br,
  input  logic [FRAC_W-1:0]   fx,
  output logic [CW+FRAC_W-1:0] top_r,
  output logic [CW+FRAC_W-1:0] bot_r
);

  localparam int HW = CW + FRAC_W;

  logic [FRAC_W:0] inv_x;
  logic [HW-1:0]   top_nxt;
  logic [HW-1:0]   bot_nxt;

  assign inv_x   = WEIGHT_ONE - {1'b0, fx};
  assign top_nxt = HW'(tl) * HW'(inv_x) + HW'(tr) * HW'(fx);
  assign bot_nxt = HW'(bl) * HW'(inv_x) + HW'(br) * HW'(fx);

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    bot_r <= bot_nxt;
  end

endmodule

>>> rtl/core/rbs_vblend.sv
// Vertical blend and rounding of one color channel.
`timescale 1ns / 1ps

module rbs_vblend
  import rbs_pkg::*;
#(
  parameter int CW = 5
) (
  input  logic                 clk,
  input  logic [CW+FRAC_W-1:0] top,
  input  logic [CW+FRAC_W-1:0] bot,
  input  logic [FRAC_W-1:0]    fy,
  output logic [CW-1:0]        chan_r
);

  localparam int VW = CW + 2 * FRAC_W;

  logic [FRAC_W:0] inv_y;
  logic [VW-1:0]   sum;
  logic [CW-1:0]   chan_nxt;

  assign inv_y    = WEIGHT_ONE - {1'b0, fy};
  assign sum      = VW'(top) * VW'(inv_y) + VW'(bot) * VW'(fy) + VW'(ROUND_BIAS);
  assign chan_nxt = sum[VW-1:OUT_SHIFT];

  always_ff @(posedge clk) begin
    chan_r <= chan_nxt;
  end

endmodule

>>> rtl/core/rbs_finish.sv
// Output stage: uniform bypass, grey detect and result registers.
`timescale 1ns / 1ps

module rbs_finish
  import rbs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  rbs_s2_t          side,
  input  logic [RED_W-1:0] red,
  input  logic [GRN_W-1:0] grn,
  input  logic [BLU_W-1:0] blu,
  input  logic             themed,
  output logic             valid_r,
  output logic [PIX_W-1:0] pix_r,
  output logic             we_r,
  output logic             pal_r,
  output logic [GRN_W-1:0] idx_r
);

  logic [PIX_W-1:0] pix_nxt;
  logic             pal_nxt;

  // Pass a uniform neighborhood through untouched
  assign pix_nxt = side.uni ? side.pix : {red, grn, blu};

  assign pal_nxt = themed && side.we
                && (pix_nxt[RED_LSB +: RED_W] == pix_nxt[BLU_LSB +: BLU_W])
                && (pix_nxt[GRN_LSB+1 +: RED_W] == pix_nxt[RED_LSB +: RED_W]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= side.vld;
    end
    pix_r <= pix_nxt;
    we_r  <= side.we;
    pal_r <= pal_nxt;
    idx_r <= pix_nxt[GRN_LSB +: GRN_W];
  end

endmodule

>>> rtl/core/rgb565_bilinear_sampler_top.sv
// Top level of the RGB565 bilinear sampler.
`timescale 1ns / 1ps

// Blends four neighboring RGB565 pixels with 8-bit x and y fractions and
// rounds each channel. A transaction is taken on every cycle start is high;
// busy never rises, so one pixel per clock is sustained. Each result appears
// on the out_ ports for one cycle with out_valid high, once its start has
// passed the horizontal blend, vertical blend and output register stages.
// The receiver cannot stall, so results must be captured when
// out_valid is high. write_enable is low when all four pixels are zero.
// cfg_themed_enable is taken whenever cfg_valid is high; change it only
// while no transaction is in flight.
module rgb565_bilinear_sampler_top
  import rbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [PIX_W-1:0]  in_top_left,
  input  logic [PIX_W-1:0]  in_top_right,
  input  logic [PIX_W-1:0]  in_bottom_left,
  input  logic [PIX_W-1:0]  in_bottom_right,
  input  logic [FRAC_W-1:0] in_frac_x,
  input  logic [FRAC_W-1:0] in_frac_y,
  output logic              out_valid,
  output logic [PIX_W-1:0]  out_blended_pixel,
  output logic              out_write_enable,
  output logic              out_use_palette,
  output logic [GRN_W-1:0]  out_palette_index,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_themed_enable
);

  logic    themed_r;
  rbs_s1_t s1_nxt;
  rbs_s1_t s1_r;
  rbs_s2_t s2_r;

  logic [RED_W+FRAC_W-1:0] red_top, red_bot;
  logic [GRN_W+FRAC_W-1:0] grn_top, grn_bot;
  logic [BLU_W+FRAC_W-1:0] blu_top, blu_bot;
  logic [RED_W-1:0]        red_v;
  logic [GRN_W-1:0]        grn_v;
  logic [BLU_W-1:0]        blu_v;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  assign s1_nxt.vld = start;
  assign s1_nxt.uni = (in_top_left == in_top_right) && (in_top_left == in_bottom_left)
                   && (in_top_left == in_bottom_right);
  assign s1_nxt.we  = |(in_top_left | in_top_right | in_bottom_left | in_bottom_right);
  assign s1_nxt.pix = in_top_left;
  assign s1_nxt.fy  = in_frac_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      themed_r   <= 1'b0;
      s1_r.vld   <= 1'b0;
      s2_r.vld   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        themed_r <= cfg_themed_enable;
      end
      s1_r.vld <= s1_nxt.vld;
      s2_r.vld <= s1_r.vld;
    end
    s1_r.uni <= s1_nxt.uni;
    s1_r.we  <= s1_nxt.we;
    s1_r.pix <= s1_nxt.pix;
    s1_r.fy  <= s1_nxt.fy;
    s2_r.uni <= s1_r.uni;
    s2_r.we  <= s1_r.we;
    s2_r.pix <= s1_r.pix;
  end

  rbs_hblend #(.CW(RED_W)) u_h_red (
    .clk(clk),
    .tl(in_top_left[RED_LSB +: RED_W]), .tr(in_top_right[RED_LSB +: RED_W]),
    .bl(in_bottom_left[RED_LSB +: RED_W]), .br(in_bottom_right[RED_LSB +: RED_W]),
    .fx(in_frac_x), .top_r(red_top), .bot_r(red_bot)
  );

  rbs_hblend #(.CW(GRN_W)) u_h_grn (
    .clk(clk),
    .tl(in_top_left[GRN_LSB +: GRN_W]), .tr(in_top_right[GRN_LSB +: GRN_W]),
    .bl(in_bottom_left[GRN_LSB +: GRN_W]), .br(in_bottom_right[GRN_LSB +: GRN_W]),
    .fx(in_frac_x), .top_r(grn_top), .bot_r(grn_bot)
  );

  rbs_hblend #(.CW(BLU_W)) u_h_blu (
    .clk(clk),
    .tl(in_top_left[BLU_LSB +: BLU_W]), .tr(in_top_right[BLU_LSB +: BLU_W]),
    .bl(in_bottom_left[BLU_LSB +: BLU_W]), .br(in_bottom_right[BLU_LSB +: BLU_W]),
    .fx(in_frac_x), .top_r(blu_top), .bot_r(blu_bot)
  );

  rbs_vblend #(.CW(RED_W)) u_v_red (
    .clk(clk), .top(red_top), .bot(red_bot), .fy(s1_r.fy), .chan_r(red_v)
  );

  rbs_vblend #(.CW(GRN_W)) u_v_grn (
    .clk(clk), .top(grn_top), .bot(grn_bot), .fy(s1_r.fy), .chan_r(grn_v)
  );

  rbs_vblend #(.CW(BLU_W)) u_v_blu (
    .clk(clk), .top(blu_top), .bot(blu_bot), .fy(s1_r.fy), .chan_r(blu_v)
  );

  rbs_finish u_finish (
    .clk(clk),
    .rst_n(rst_n),
    .side(s2_r),
    .red(red_v),
    .grn(grn_v),
    .blu(blu_v),
    .themed(themed_r),
    .valid_r(out_valid),
    .pix_r(out_blended_pixel),
    .we_r(out_write_enable),
    .pal_r(out_use_palette),
    .idx_r(out_palette_index)
  );

endmodule
